// ----- rtl/sst_pkg.sv -----
// package for the sparse slot table unit
// opcodes, sequencer states, scan handshake structs and fixed port widths
// no dependencies
package sst_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_READ      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_IS_ALLOC  = 3'd4,
    OP_CONTAINS  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic start;
    logic find_key;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

// ----- rtl/sparse_slot_table_unit.sv -----
// Sparse slot table unit. A command is taken when start_i is high and busy_o
// is low; its single result appears for exactly one cycle with done_o high
// and cannot be held off, so the receiver must take it in that cycle.
// Remove, read, write, is_allocated, unused codes and an add with no freed
// slot below the high-water mark give their result without a scan.
// Contains, and an add that reuses a freed slot, walk the slots below the
// high-water mark one per cycle through the shared scan unit and its single
// ram read port. busy_o is low again in the cycle done_o is shown.
// No clearing pass is needed after reset.
// depends on sst_pkg, sst_ram, sst_scan, sst_ctrl
module sparse_slot_table_unit import sst_pkg::*; #(
  parameter int unsigned CAPACITY      = 256,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               done_o,
  output logic [SLOT_W-1:0]  result_slot_o,
  output logic [VALUE_W-1:0] read_value_o,
  output logic               flag_o,
  output logic               full_res_o,
  output logic [COUNT_W-1:0] used_count_o,
  output logic [COUNT_W-1:0] high_water_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [IdxW-1:0]          rd_addr, wr_addr, scan_idx, scan_addr;
  logic                     elem_we, alloc_we;
  logic [ELEMENT_WIDTH-1:0] elem_wdata, elem_rdata, scan_key;
  logic [0:0]               alloc_wdata, alloc_rdata;
  logic [CntW-1:0]          scan_limit;
  scan_req_t                scan_req;
  scan_rsp_t                scan_rsp;

  sst_ctrl #(
    .Capacity (CAPACITY),
    .ElemW    (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .operation_i   (operation_i),
    .slot_i        (slot_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .result_slot_o (result_slot_o),
    .read_value_o  (read_value_o),
    .flag_o        (flag_o),
    .full_res_o    (full_res_o),
    .used_count_o  (used_count_o),
    .high_water_o  (high_water_o),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .elem_we_o     (elem_we),
    .elem_wdata_o  (elem_wdata),
    .alloc_we_o    (alloc_we),
    .alloc_wdata_o (alloc_wdata),
    .elem_rdata_i  (elem_rdata),
    .alloc_rdata_i (alloc_rdata),
    .scan_req_o    (scan_req),
    .scan_limit_o  (scan_limit),
    .scan_key_o    (scan_key),
    .scan_rsp_i    (scan_rsp),
    .scan_idx_i    (scan_idx),
    .scan_addr_i   (scan_addr)
  );

  sst_scan #(
    .Depth (CAPACITY),
    .Width (ELEMENT_WIDTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (scan_req),
    .limit_i (scan_limit),
    .key_i   (scan_key),
    .alloc_i (alloc_rdata[0]),
    .elem_i  (elem_rdata),
    .addr_o  (scan_addr),
    .rsp_o   (scan_rsp),
    .idx_o   (scan_idx)
  );

  sst_ram #(
    .Width (ELEMENT_WIDTH),
    .Depth (CAPACITY)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (wr_addr),
    .wdata_i (elem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (elem_rdata)
  );

  sst_ram #(
    .Width (1),
    .Depth (CAPACITY)
  ) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_we),
    .waddr_i (wr_addr),
    .wdata_i (alloc_wdata),
    .raddr_i (rd_addr),
    .rdata_o (alloc_rdata)
  );

endmodule

// ----- rtl/sst_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module sst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sst_scan.sv -----
// shared scan unit: walks slots below the high-water mark, one per cycle,
// looking for a free slot or an allocated slot holding the key
// depends on sst_pkg
module sst_scan import sst_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scan_req_t       req_i,
  input  logic [CntW-1:0] limit_i,
  input  logic [Width-1:0] key_i,
  input  logic            alloc_i,
  input  logic [Width-1:0] elem_i,
  output logic [IdxW-1:0] addr_o,
  output scan_rsp_t       rsp_o,
  output logic [IdxW-1:0] idx_o
);

  logic            run_q, run_d;
  logic            chk_q, chk_d;
  logic            mode_q, mode_d;
  logic [CntW-1:0] next_q, next_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic            issue, match, hit, exhausted;

  assign issue     = run_q && (next_q < limit_i);
  assign match     = mode_q ? (alloc_i && (elem_i == key_i)) : !alloc_i;
  assign hit       = run_q && chk_q && match;
  assign exhausted = run_q && !chk_q && !issue;

  assign addr_o     = next_q[IdxW-1:0];
  assign rsp_o.done = hit || exhausted;
  assign rsp_o.hit  = hit;
  assign idx_o      = chk_idx_q;

  always_comb begin
    run_d     = run_q;
    chk_d     = chk_q;
    mode_d    = mode_q;
    next_d    = next_q;
    chk_idx_d = chk_idx_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      chk_d  = 1'b0;
      mode_d = req_i.find_key;
      next_d = '0;
    end else if (run_q) begin
      if (rsp_o.done) begin
        run_d = 1'b0;
        chk_d = 1'b0;
      end else begin
        chk_d     = issue;
        chk_idx_d = next_q[IdxW-1:0];
        if (issue) begin
          next_d = next_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      chk_q <= 1'b0;
    end else begin
      run_q <= run_d;
      chk_q <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    next_q    <= next_d;
    chk_idx_q <= chk_idx_d;
  end

endmodule

// ----- rtl/sst_ctrl.sv -----
// sequencer of the sparse slot table: command decode, counters, ram writes
// and result registers
// depends on sst_pkg
module sst_ctrl import sst_pkg::*; #(
  parameter int unsigned Capacity = 256,
  parameter int unsigned ElemW    = 32,
  localparam int unsigned IdxW = $clog2(Capacity),
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [SLOT_W-1:0]  result_slot_o,
  output logic [VALUE_W-1:0] read_value_o,
  output logic               flag_o,
  output logic               full_res_o,
  output logic [COUNT_W-1:0] used_count_o,
  output logic [COUNT_W-1:0] high_water_o,
  output logic [IdxW-1:0]    rd_addr_o,
  output logic [IdxW-1:0]    wr_addr_o,
  output logic               elem_we_o,
  output logic [ElemW-1:0]   elem_wdata_o,
  output logic               alloc_we_o,
  output logic [0:0]         alloc_wdata_o,
  input  logic [ElemW-1:0]   elem_rdata_i,
  input  logic [0:0]         alloc_rdata_i,
  output scan_req_t          scan_req_o,
  output logic [CntW-1:0]    scan_limit_o,
  output logic [ElemW-1:0]   scan_key_o,
  input  scan_rsp_t          scan_rsp_i,
  input  logic [IdxW-1:0]    scan_idx_i,
  input  logic [IdxW-1:0]    scan_addr_i
);

  localparam int unsigned CmpW = (CntW > SLOT_W) ? CntW : SLOT_W;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [VALUE_W-1:0]   value_q;
  logic [CntW-1:0]      hwm_q, hwm_d;
  logic [CntW-1:0]      used_q, used_d;
  logic                 done_q, done_d;
  logic [SLOT_W-1:0]    rslot_q, rslot_d;
  logic [VALUE_W-1:0]   rval_q, rval_d;
  logic                 flag_q, flag_d;
  logic                 full_q, full_d;
  logic [ElemW-1:0]     elem_val;
  logic [VALUE_W-1:0]   rd_val;
  logic [IdxW-1:0]      slot_idx;
  logic                 in_range, has_hole, is_full, accept;

  for (genvar b = 0; b < ElemW; b++) begin : g_elem_val
    if (b < VALUE_W) begin : g_bit
      assign elem_val[b] = value_q[b];
    end else begin : g_zero
      assign elem_val[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < VALUE_W; b++) begin : g_rd_val
    if (b < ElemW) begin : g_bit
      assign rd_val[b] = elem_rdata_i[b];
    end else begin : g_zero
      assign rd_val[b] = 1'b0;
    end
  end

  assign accept   = start_i && (state_q == ST_IDLE);
  assign slot_idx = IdxW'(slot_q);
  assign in_range = CmpW'(slot_q) < CmpW'(hwm_q);
  assign has_hole = used_q != hwm_q;
  assign is_full  = hwm_q == CntW'(Capacity);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (op_q)
          OP_ADD:      state_d = has_hole ? ST_SCAN : ST_IDLE;
          OP_REMOVE,
          OP_READ,
          OP_IS_ALLOC: state_d = in_range ? ST_FETCH : ST_IDLE;
          OP_CONTAINS: state_d = ST_SCAN;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_FETCH: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_rsp_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    hwm_d         = hwm_q;
    used_d        = used_q;
    done_d        = 1'b0;
    rslot_d       = rslot_q;
    rval_d        = rval_q;
    flag_d        = flag_q;
    full_d        = full_q;
    wr_addr_o     = slot_idx;
    elem_we_o     = 1'b0;
    elem_wdata_o  = elem_val;
    alloc_we_o    = 1'b0;
    alloc_wdata_o = 1'b1;
    scan_req_o    = '0;
    rd_addr_o     = (state_q == ST_SCAN) ? scan_addr_i : slot_idx;
    case (state_q)
      ST_DECODE: begin
        case (op_q)
          OP_ADD: begin
            if (has_hole) begin
              scan_req_o.start    = 1'b1;
              scan_req_o.find_key = 1'b0;
            end else begin
              done_d  = 1'b1;
              rslot_d = '0;
              rval_d  = '0;
              flag_d  = 1'b0;
              full_d  = is_full;
              if (!is_full) begin
                wr_addr_o  = hwm_q[IdxW-1:0];
                elem_we_o  = 1'b1;
                alloc_we_o = 1'b1;
                hwm_d      = hwm_q + CntW'(1);
                used_d     = used_q + CntW'(1);
                rslot_d    = SLOT_W'(hwm_q);
                flag_d     = 1'b1;
              end
            end
          end
          OP_REMOVE,
          OP_READ,
          OP_IS_ALLOC: begin
            if (!in_range) begin
              done_d  = 1'b1;
              rslot_d = '0;
              rval_d  = '0;
              flag_d  = 1'b0;
              full_d  = 1'b0;
            end
          end
          OP_WRITE: begin
            done_d    = 1'b1;
            rslot_d   = '0;
            rval_d    = '0;
            flag_d    = in_range;
            full_d    = 1'b0;
            elem_we_o = in_range;
          end
          OP_CONTAINS: begin
            scan_req_o.start    = 1'b1;
            scan_req_o.find_key = 1'b1;
          end
          default: begin
            done_d  = 1'b1;
            rslot_d = '0;
            rval_d  = '0;
            flag_d  = 1'b0;
            full_d  = 1'b0;
          end
        endcase
      end
      ST_FETCH: begin
        done_d  = 1'b1;
        rslot_d = '0;
        rval_d  = '0;
        flag_d  = 1'b0;
        full_d  = 1'b0;
        case (op_q)
          OP_REMOVE: begin
            if (alloc_rdata_i[0]) begin
              alloc_we_o    = 1'b1;
              alloc_wdata_o = 1'b0;
              used_d        = used_q - CntW'(1);
            end
          end
          OP_READ: begin
            rval_d = rd_val;
            flag_d = 1'b1;
          end
          OP_IS_ALLOC: flag_d = alloc_rdata_i[0];
          default: flag_d = 1'b0;
        endcase
      end
      ST_SCAN: begin
        if (scan_rsp_i.done) begin
          done_d  = 1'b1;
          rslot_d = '0;
          rval_d  = '0;
          full_d  = 1'b0;
          flag_d  = scan_rsp_i.hit;
          if (op_q == OP_ADD) begin
            wr_addr_o  = scan_idx_i;
            elem_we_o  = 1'b1;
            alloc_we_o = 1'b1;
            used_d     = used_q + CntW'(1);
            rslot_d    = SLOT_W'(scan_idx_i);
            flag_d     = 1'b1;
          end
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hwm_q   <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hwm_q   <= hwm_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(operation_i);
      slot_q  <= slot_i;
      value_q <= value_i;
    end
    rslot_q <= rslot_d;
    rval_q  <= rval_d;
    flag_q  <= flag_d;
    full_q  <= full_d;
  end

  assign busy_o        = state_q != ST_IDLE;
  assign done_o        = done_q;
  assign result_slot_o = rslot_q;
  assign read_value_o  = rval_q;
  assign flag_o        = flag_q;
  assign full_res_o    = full_q;
  assign used_count_o  = COUNT_W'(used_q);
  assign high_water_o  = COUNT_W'(hwm_q);
  assign scan_limit_o  = hwm_q;
  assign scan_key_o    = elem_val;

endmodule

// ----- rtl/sst_checker.sv -----
// port-level checks for the sparse slot table unit, bound to the top level
// depends on sparse_slot_table_unit port names
module sst_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       flag_o,
  input logic       full_res_o,
  input logic [8:0] used_count_o,
  input logic [8:0] high_water_o
);

  // accepted command keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("no busy after accepted command");

  // result cycle frees the unit for the next transfer
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("busy while result shown");

  // one result per command, never two in a row
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back to back results");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> used_count_o <= high_water_o)
    else $error("allocated count above high-water mark");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && full_res_o |-> !flag_o && (used_count_o == high_water_o))
    else $error("inconsistent full result");

endmodule

bind sparse_slot_table_unit sst_port_checker u_sst_checker (.*);
